[rtl/galvo_triangle_and_trigger_gen_assert.svh]
// Assertion macros used by gttg_ctrl, the galvo triangle generator's controller.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef GALVO_TRIANGLE_AND_TRIGGER_GEN_ASSERT_SVH
`define GALVO_TRIANGLE_AND_TRIGGER_GEN_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GTTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GTTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gttg_pkg.sv]
// Shared types and constants for the galvo triangle and trigger generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gttg_pkg;

  // Field and register widths.
  localparam int PERIOD_W   = 21;
  localparam int AMP_W      = 16;
  localparam int MASK_W     = 4;
  localparam int DAC_BITS   = 16;
  localparam int IDX_W      = 2;
  localparam int CFG_DATA_W = PERIOD_W;

  // Period limits and reset value.
  localparam int MAX_PERIOD = 1080000;
  localparam int MIN_PERIOD = 3600;
  localparam int PERIOD_RST = 24007;

  // Gate window edges in samples.
  localparam int LASER_START        = 240;
  localparam int LASER_END_BACKOFF  = 480;
  localparam int CAMERA_START_DELAY = 120;
  localparam int CAMERA_END_DELAY   = 2400;

  // Ramp arithmetic widths.
  localparam int TERM_W = PERIOD_W + 1;
  localparam int PROD_W = AMP_W + TERM_W;
  localparam int MAG_W  = PROD_W - 1;
  localparam int DVD_W  = PROD_W;
  localparam int QUO_W  = AMP_W + 1;
  localparam int DIV_W  = PERIOD_W;
  localparam int CNT_W  = $clog2(QUO_W);
  localparam int SUM_W  = (QUO_W + 2 > DAC_BITS + 1) ? QUO_W + 2 : DAC_BITS + 1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = DAC_BITS + MASK_W + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [IDX_W-1:0] {
    CFG_PERIOD     = 2'd0,
    CFG_AMPLITUDE  = 2'd1,
    CFG_OFFSET     = 2'd2,
    CFG_LASER_MASK = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } gttg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic mul;
    logic prep;
    logic div_step;
    logic out_load;
  } gttg_cmd_t;

endpackage

[rtl/gttg_ctrl.sv]
// Sequencing controller for the galvo triangle generator.
// Depends on gttg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "galvo_triangle_and_trigger_gen_assert.svh"

module gttg_ctrl
  import gttg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output gttg_cmd_t cmd
);

  gttg_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  // State, step counter and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Load the result once the output register is free or being drained.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  `GTTG_ASSERT_NOW(a_load_no_overwrite, cmd.out_load, !out_valid_r || out_tready, "result loaded over an untaken beat")
  `GTTG_ASSERT_NEXT(a_div_ends, state_r == ST_DIV && cnt_r == CNT_LAST, state_r == ST_FIN, "division did not end after the last step")
  `GTTG_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready, state_r == ST_MUL && !in_tready, "accepted beat did not start the multiply")
  `GTTG_ASSERT_NEXT(a_load_shows, cmd.out_load, out_tvalid, "loaded result not presented")

endmodule

[rtl/gttg_dp.sv]
// Datapath: configuration registers, position counter, ramp multiplier,
// restoring divider, gate windows and output register. Depends on gttg_pkg.
`timescale 1ns / 1ps

module gttg_dp
  import gttg_pkg::*;
(
  input  logic                       clk,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       restart,
  input  gttg_cmd_t                  cmd,
  output logic signed [DAC_BITS-1:0] dac_code,
  output logic [MASK_W-1:0]          laser_gates,
  output logic                       camera_gate,
  output logic                       period_start,
  input  logic                       rst_n
);

  logic [PERIOD_W-1:0]      period_r;
  logic signed [AMP_W-1:0]  amp_r;
  logic signed [AMP_W-1:0]  offset_r;
  logic [MASK_W-1:0]        mask_r;
  logic [PERIOD_W-1:0]      pos_r;
  logic [PERIOD_W-1:0]      i_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DIV_W-1:0]         den_r;
  logic                     neg_r;
  logic [DIV_W-1:0]         rem_r;
  logic [QUO_W-1:0]         quo_r;
  logic [MASK_W-1:0]        gates_r;
  logic                     cam_r;
  logic                     start_r;
  logic signed [DAC_BITS-1:0] dac_r;
  logic [MASK_W-1:0]        gates_out_r;
  logic                     cam_out_r;
  logic                     start_out_r;

  logic [PERIOD_W-1:0]      half;
  logic [PERIOD_W-1:0]      fall_den;
  logic [PERIOD_W-1:0]      clamped;
  logic [PERIOD_W-1:0]      i_cur;
  logic [PERIOD_W:0]        i_inc;
  logic                     rising;
  logic [TERM_W:0]          term_wide;
  logic signed [PROD_W-1:0] amp_ext;
  logic signed [PROD_W-1:0] term_ext;
  logic [MAG_W-1:0]         mag;
  logic [DVD_W-1:0]         dividend;
  logic [DIV_W:0]           trial;
  logic                     fits;
  logic signed [SUM_W-1:0]  ramp;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DAC_BITS-1:0] sat;

  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (DAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (DAC_BITS - 1)) - SUM_W'(1);

  // Period clamping on write.
  always_comb begin
    if (cfg_data > PERIOD_W'(MAX_PERIOD)) begin
      clamped = PERIOD_W'(MAX_PERIOD);
    end else if (cfg_data < PERIOD_W'(MIN_PERIOD)) begin
      clamped = PERIOD_W'(MIN_PERIOD);
    end else begin
      clamped = cfg_data;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_W'(PERIOD_RST);
      amp_r    <= '0;
      offset_r <= '0;
      mask_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PERIOD:     period_r <= clamped;
        CFG_AMPLITUDE:  amp_r    <= cfg_data[AMP_W-1:0];
        CFG_OFFSET:     offset_r <= cfg_data[AMP_W-1:0];
        CFG_LASER_MASK: mask_r   <= cfg_data[MASK_W-1:0];
        default:        ;
      endcase
    end
  end

  // Position of this sample and of the next one.
  assign i_cur = (restart || pos_r >= period_r) ? '0 : pos_r;
  assign i_inc = {1'b0, i_cur} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.load_item) begin
      pos_r <= (i_inc >= {1'b0, period_r}) ? '0 : i_inc[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      i_r <= i_cur;
    end
  end

  // Ramp numerator term and denominator for the current half.
  assign half     = period_r >> 1;
  assign fall_den = period_r - half - 1'b1;
  assign rising   = i_r < half;

  always_comb begin
    if (rising) begin
      term_wide = {1'b0, i_r, 1'b0} - {2'b00, half};
    end else begin
      term_wide = {2'b00, fall_den} + {1'b0, half, 1'b0} - {1'b0, i_r, 1'b0};
    end
  end

  assign amp_ext  = PROD_W'(amp_r);
  assign term_ext = PROD_W'($signed(term_wide[TERM_W-1:0]));

  // Multiply stage and gate windows.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r  <= amp_ext * term_ext;
      den_r   <= rising ? half : fall_den;
      gates_r <= (i_r > PERIOD_W'(LASER_START) &&
                  i_r < half - PERIOD_W'(LASER_END_BACKOFF)) ? mask_r : '0;
      cam_r   <= ({1'b0, i_r} > {1'b0, half} + (PERIOD_W + 1)'(CAMERA_START_DELAY)) &&
                 ({1'b0, i_r} < {1'b0, half} + (PERIOD_W + 1)'(CAMERA_END_DELAY));
      start_r <= (i_r == '0);
    end
  end

  // Rounded division: (2|num| + d) / (2d), restoring, one quotient bit a step.
  assign mag      = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
  assign dividend = {mag, 1'b0} + DVD_W'(den_r);
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign fits     = trial >= {den_r, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_r <= dividend[DVD_W-1:QUO_W];
      quo_r <= dividend[QUO_W-1:0];
      neg_r <= prod_r[PROD_W-1];
    end else if (cmd.div_step) begin
      rem_r <= fits ? DIV_W'(trial - {den_r, 1'b0}) : trial[DIV_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  // Sign, offset and saturation.
  assign ramp = neg_r ? -SUM_W'($signed({1'b0, quo_r})) : SUM_W'($signed({1'b0, quo_r}));
  assign sum  = ramp + SUM_W'(offset_r);

  always_comb begin
    if (sum < SAT_LO) begin
      sat = SAT_LO[DAC_BITS-1:0];
    end else if (sum > SAT_HI) begin
      sat = SAT_HI[DAC_BITS-1:0];
    end else begin
      sat = sum[DAC_BITS-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dac_r       <= sat;
      gates_out_r <= gates_r;
      cam_out_r   <= cam_r;
      start_out_r <= start_r;
    end
  end

  assign dac_code     = dac_r;
  assign laser_gates  = gates_out_r;
  assign camera_gate  = cam_out_r;
  assign period_start = start_out_r;

endmodule

[rtl/galvo_triangle_and_trigger_gen.sv]
// Galvo triangle scan generator with laser and camera gate windows.
// Each input beat is one sample tick and returns one result beat: the
// saturated signed DAC code of a triangle ramp (up over the first half of
// the period, down over the rest, scaled by the amplitude and shifted by
// the offset), the masked laser gates, the camera gate and a period start
// flag. An accepted beat passes the multiply step, the divider preparation,
// the 17-step restoring divider that rounds the ramp value and the output
// load, which waits while an untaken result holds the output register. The
// next beat is accepted as soon as the result sits in the output register.
// There is no clearing pass after reset. The user must write configuration
// only while no sample is in flight; the block itself does not enforce it.
// Depends on gttg_pkg, gttg_ctrl and gttg_dp.
`timescale 1ns / 1ps

module galvo_triangle_and_trigger_gen
  import gttg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [0] restart, rest zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata    // dac_code, laser_gates, camera_gate, period_start
);

  gttg_cmd_t                  cmd;
  logic signed [DAC_BITS-1:0] dac_code;
  logic [MASK_W-1:0]          laser_gates;
  logic                       camera_gate;
  logic                       period_start;

  // Sequencer.
  gttg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Arithmetic and state.
  gttg_dp u_dp (
    .clk          (clk),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart      (in_tdata[0]),
    .cmd          (cmd),
    .dac_code     (dac_code),
    .laser_gates  (laser_gates),
    .camera_gate  (camera_gate),
    .period_start (period_start),
    .rst_n        (rst_n)
  );

  // Result beat packing, lowest field first.
  assign out_tdata = OUT_TDATA_W'({period_start, camera_gate, laser_gates, dac_code});

endmodule

[verif/galvo_triangle_and_trigger_gen_test.sv]
// Self-checking testbench for galvo_triangle_and_trigger_gen.
// A scoreboard predicts every result beat. Directed and random sample ticks
// run under random stalls on both streams. Depends on gttg_pkg and the RTL.
`timescale 1ns / 1ps

module galvo_triangle_and_trigger_gen_test;
  import gttg_pkg::*;

  // Scan limits and gate window edges, in samples.
  localparam longint FRAME_MIN        = 3600;
  localparam longint FRAME_MAX        = 1080000;
  localparam longint FRAME_AT_RESET   = 24007;
  localparam longint LASER_ON_AFTER   = 240;
  localparam longint LASER_OFF_BEFORE = 480;
  localparam longint CAMERA_ON_AFTER  = 120;
  localparam longint CAMERA_OFF_AFTER = 2400;
  localparam longint DAC_HI           = (longint'(1) << (DAC_BITS - 1)) - 1;
  localparam longint DAC_LO           = -(longint'(1) << (DAC_BITS - 1));

  typedef struct {
    logic signed [DAC_BITS-1:0] dac;
    logic [MASK_W-1:0]          gates;
    logic                       cam;
    logic                       start;
  } scan_sample_t;

  // Tracks the scan registers and the sample position, and keeps the
  // expected result beats in order of their input beats.
  class scan_scoreboard;
    longint            frame_len;
    longint            amplitude;
    longint            offset;
    logic [MASK_W-1:0] laser_mask;
    longint            position;
    scan_sample_t      pending[$];
    int                errors;
    int                checked;

    function new();
      frame_len  = FRAME_AT_RESET;
      amplitude  = 0;
      offset     = 0;
      laser_mask = '0;
      position   = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      longint n;
      case (idx)
        CFG_PERIOD: begin
          n = data;
          if (n > FRAME_MAX) n = FRAME_MAX;
          if (n < FRAME_MIN) n = FRAME_MIN;
          frame_len = n;
        end
        CFG_AMPLITUDE:  amplitude  = longint'($signed(data[AMP_W-1:0]));
        CFG_OFFSET:     offset     = longint'($signed(data[AMP_W-1:0]));
        CFG_LASER_MASK: laser_mask = data[MASK_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the sample for one accepted tick and advances the position.
    function void note_tick(logic restart);
      longint n, r, i, d, num, den, mag, q, code;
      scan_sample_t want;
      n = frame_len;
      r = n / 2;
      if (restart) position = 0;
      if (position >= n) position = 0;
      i = position;
      if (i < r) begin
        num = amplitude * (2 * i - r);
        den = r;
      end else begin
        d   = n - 1 - r;
        num = amplitude * (d - 2 * (i - r));
        den = d;
      end
      // Round to nearest, ties away from zero.
      mag  = (num < 0) ? -num : num;
      q    = (2 * mag + den) / (2 * den);
      code = ((num < 0) ? -q : q) + offset;
      if (code < DAC_LO) code = DAC_LO;
      if (code > DAC_HI) code = DAC_HI;
      want.dac   = code[DAC_BITS-1:0];
      want.gates = (i > LASER_ON_AFTER && i < r - LASER_OFF_BEFORE) ? laser_mask : '0;
      want.cam   = (i > r + CAMERA_ON_AFTER && i < r + CAMERA_OFF_AFTER);
      want.start = (i == 0);
      pending.push_back(want);
      position = (i + 1 >= n) ? 0 : i + 1;
    endfunction

    function void check_sample(logic [OUT_TDATA_W-1:0] beat);
      scan_sample_t want;
      logic signed [DAC_BITS-1:0] dac;
      logic [MASK_W-1:0] gates;
      logic cam;
      logic start;
      if (pending.size() == 0) begin
        $error("Result beat with no sample pending: tdata=%h", beat);
        errors++;
        return;
      end
      want  = pending.pop_front();
      dac   = beat[DAC_BITS-1:0];
      gates = beat[DAC_BITS +: MASK_W];
      cam   = beat[DAC_BITS + MASK_W];
      start = beat[DAC_BITS + MASK_W + 1];
      checked++;
      if (dac !== want.dac) begin
        $error("dac_code: expected %0d, got %0d", want.dac, dac);
        errors++;
      end
      if (gates !== want.gates) begin
        $error("laser_gates: expected %h, got %h", want.gates, gates);
        errors++;
      end
      if (cam !== want.cam) begin
        $error("camera_gate: expected %b, got %b", want.cam, cam);
        errors++;
      end
      if (start !== want.start) begin
        $error("period_start: expected %b, got %b", want.start, start);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // [0] restart, rest zero
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;   // dac_code, laser_gates, camera_gate, period_start

  scan_scoreboard scoreboard = new();
  int  ticks_sent = 0;
  int  settings_used = 0;
  bit  hold_output = 1'b0;
  bit  no_gaps = 1'b0;

  galvo_triangle_and_trigger_gen u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both streams are observed with the values they held before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) scoreboard.note_tick(in_tdata[0]);
      if (out_tvalid && out_tready) scoreboard.check_sample(out_tdata);
    end
  end

  // Result side: short stalls, a few long ones, long ready stretches, and
  // one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    int stall;
    int run;
    int roll;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (hold_output) begin
        hold_output = 1'b0;
        stall = 400;
      end else if (roll < 90) begin
        stall = $urandom_range(1, 3);
      end else begin
        stall = $urandom_range(20, 60);
      end
      out_tready <= 1'b0;
      repeat (stall) @(posedge clk);
      out_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one sample tick and returns at the edge that accepts it. Valid
  // stays high when the next beat follows without a gap.
  task automatic send_tick(input bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // A restart odds of zero gives an unbroken run of ticks.
  task automatic run_ticks(input int count, input int restart_odds);
    repeat (count) send_tick(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
  endtask

  // Stops offering beats and waits until every expected result has come.
  // One edge passes first so that the last accepted beat has been noted.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    scoreboard.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Loads all four scan registers once the block is idle. Bits above a
  // register's width carry random values, which the block must ignore.
  task automatic set_scan(input int frame, input int amp, input int ofs, input int mask);
    logic [CFG_DATA_W-1:0] word;
    drain_results();
    write_reg(CFG_PERIOD, frame[CFG_DATA_W-1:0]);
    word = CFG_DATA_W'($urandom);
    word[AMP_W-1:0] = amp[AMP_W-1:0];
    write_reg(CFG_AMPLITUDE, word);
    word = CFG_DATA_W'($urandom);
    word[AMP_W-1:0] = ofs[AMP_W-1:0];
    write_reg(CFG_OFFSET, word);
    word = CFG_DATA_W'($urandom);
    word[MASK_W-1:0] = mask[MASK_W-1:0];
    write_reg(CFG_LASER_MASK, word);
    settings_used++;
  endtask

  initial begin : stimulus
    int frame;
    int ofs;
    int roll;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_PERIOD;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero amplitude over the default period.
    run_ticks(2, 0);

    // Period below the minimum is clamped; full positive amplitude.
    set_scan(5, 32767, 0, 'hF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // Most negative amplitude with top offset saturates high.
    set_scan(0, -32768, 32767, 'h5);
    send_tick(1'b1);
    run_ticks(2, 0);

    // Full amplitude with bottom offset saturates low.
    set_scan(3599, 32767, -32768, 'hA);
    send_tick(1'b1);
    run_ticks(2, 0);

    // Periods above the maximum are clamped, and both exact limits.
    set_scan('h1FFFFF, 12345, -1000, 'h3);
    send_tick(1'b1);
    run_ticks(2, 0);
    set_scan(1080001, -1, 1, 'h0);
    run_ticks(2, 0);
    set_scan(3600, 100, 0, 'hC);
    send_tick(1'b1);
    send_tick(1'b0);
    set_scan(1080000, -32768, -32768, 'h9);
    run_ticks(2, 0);

    // Start of a frame at an even period: the rising ramp and the opening of
    // the laser window. The output is held off for a long stretch early on,
    // and the input pauses midway.
    ofs = $urandom_range(0, 4000);
    set_scan(3700, 32767, ofs - 2000, $urandom_range(1, 15));
    send_tick(1'b1);
    run_ticks(100, 0);
    hold_output = 1'b1;
    run_ticks(300, 0);
    drain_results();
    run_ticks(100, 0);

    // A period change mid-frame keeps the position running.
    set_scan(3600, 20000, 0, $urandom_range(0, 15));
    run_ticks(40, 0);

    // Odd period, back to back.
    no_gaps = 1'b1;
    ofs = $urandom_range(0, 65535);
    set_scan(3601, -32768, ofs, $urandom_range(0, 15));
    send_tick(1'b1);
    run_ticks(150, 0);
    no_gaps = 1'b0;

    // Random settings with occasional restarts.
    repeat (6) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) frame = $urandom_range(3600, 6000);
      else if (roll < 85) frame = $urandom_range(0, 3600);
      else frame = $urandom_range(0, 2097151);
      ofs = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535)
                                         : $urandom_range(0, 4000) - 2000;
      set_scan(frame, $urandom_range(0, 65535), ofs, $urandom_range(0, 15));
      run_ticks($urandom_range(20, 40), 10);
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (scoreboard.pending.size() != 0) begin
      $error("%0d expected samples never arrived", scoreboard.pending.size());
      scoreboard.errors++;
    end

    $display("Sent %0d sample ticks under %0d register settings, %0d result beats checked.",
             ticks_sent, settings_used, scoreboard.checked);
    $display("Frame starts at periods 3600, 3601 and 3700 covered the rising ramp, the laser %s",
             "window opening, restarts, clamping and saturation.");
    if (scoreboard.errors == 0) begin
      $display("galvo_triangle_and_trigger_gen test passed");
    end else begin
      $display("galvo_triangle_and_trigger_gen test failed");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin : watchdog
    #60_000_000;
    $display("galvo_triangle_and_trigger_gen test failed");
    $finish;
  end

endmodule

[galvo_triangle_and_trigger_gen.f]
+incdir+rtl
rtl/gttg_pkg.sv
rtl/gttg_ctrl.sv
rtl/gttg_dp.sv
rtl/galvo_triangle_and_trigger_gen.sv
verif/galvo_triangle_and_trigger_gen_test.sv
